/* sv/dts_pkg.sv */
// dts_pkg: shared types and codes for the depth-first topological sorter.
// No dependencies; imported by the interfaces, the core and its checker.
`default_nettype none
package dts_pkg;

  localparam int VERTEX_W = 6;
  localparam int CFG_W    = 7;

  typedef logic [VERTEX_W-1:0] vertex_t;
  typedef logic [CFG_W-1:0]    count_t;

  localparam logic OP_ADD_EDGE = 1'b0;
  localparam logic OP_RUN      = 1'b1;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_EADD   = 11'b000_0000_0010,
    S_ELINK  = 11'b000_0000_0100,
    S_ROOT   = 11'b000_0000_1000,
    S_RHEAD  = 11'b000_0001_0000,
    S_WALK   = 11'b000_0010_0000,
    S_POP    = 11'b000_0100_0000,
    S_EDGE   = 11'b000_1000_0000,
    S_PUSH   = 11'b001_0000_0000,
    S_EMITRD = 11'b010_0000_0000,
    S_EMITW  = 11'b100_0000_0000
  } state_t;

endpackage
`default_nettype wire

/* sv/dts_if.sv */
// dts_in_if / dts_out_if: valid/ready channels of the topological sorter.
// Depends on dts_pkg for the vertex type.
`default_nettype none
interface dts_in_if import dts_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    operation;
  vertex_t from_vertex;
  vertex_t to_vertex;
  modport source (output valid, operation, from_vertex, to_vertex, input ready);
  modport sink   (input valid, operation, from_vertex, to_vertex, output ready);
endinterface

interface dts_out_if import dts_pkg::*; ();
  logic    valid;
  logic    ready;
  vertex_t vertex;
  logic    final_item;
  logic    edges_dropped;
  modport source (output valid, vertex, final_item, edges_dropped, input ready);
  modport sink   (input valid, vertex, final_item, edges_dropped, output ready);
endinterface
`default_nettype wire

/* sv/dts_ram.sv */
// dts_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module dts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic                                 re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

/* sv/dfs_topological_sort_core.sv */
// dfs_topological_sort_core: edge loader, depth-first walker and order emitter.
// Depends on dts_pkg, dts_if and dts_ram.
//
// Edge requests (operation 0) append an edge to its source vertex's list;
// the old tail's link is patched in a second write when the list was already
// non-empty. An edge with a vertex at or above the vertex count, or sent when
// the store is full, is dropped and sets the drop flag. A run request
// (operation 1) walks depth-first from every unvisited vertex in ascending
// order using a stack held in RAM, then emits the vertices in reverse
// finishing order, final_item marking the last. Walking and emitting wait on
// registered reads of the edge, vertex, stack and finish RAMs, and emitting
// also waits while the output is stalled. No request is taken during an edge
// append or a run. When a run's last vertex enters the output register the
// edge store, visited marks and drop flag are cleared; no clearing pass is needed.
`default_nettype none
module dfs_topological_sort_core import dts_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  dts_in_if.sink      in_ch,
  dts_out_if.source   out_ch,
  input  wire logic   cfg_we,
  input  wire count_t cfg_wdata
);
  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int SW = VERTEX_W + EW + 1;

  state_t                  state_r, state_nxt;
  count_t                  nv_cfg_r, nv_cfg_nxt;
  logic [CW-1:0]           edge_cnt_r, edge_cnt_nxt;
  logic                    drop_r, drop_nxt;
  logic [MAX_VERTICES-1:0] nonempty_r, nonempty_nxt;
  logic [MAX_VERTICES-1:0] visited_r, visited_nxt;
  logic [VW-1:0]           a_r, a_nxt;
  vertex_t                 b_r, b_nxt;
  logic [EW-1:0]           e_r, e_nxt;
  logic [EW-1:0]           tail_r, tail_nxt;
  count_t                  root_r, root_nxt;
  count_t                  sp_r, sp_nxt;
  count_t                  done_r, done_nxt;
  count_t                  idx_r, idx_nxt;
  vertex_t                 top_v_r, top_v_nxt;
  logic [EW-1:0]           top_cur_r, top_cur_nxt;
  logic                    top_ok_r, top_ok_nxt;
  vertex_t                 pend_r, pend_nxt;
  logic                    out_valid_r, out_valid_nxt;
  vertex_t                 out_vertex_r, out_vertex_nxt;
  logic                    out_final_r, out_final_nxt;
  logic                    out_drop_r, out_drop_nxt;

  count_t        nv;
  logic          full;

  logic          targ_we, targ_re;
  logic [EW-1:0] targ_waddr, targ_raddr;
  vertex_t       targ_wdata, targ_rd;
  logic          link_we, link_re;
  logic [EW-1:0] link_waddr, link_raddr;
  logic [EW:0]   link_wdata, link_rd;
  logic          vm_we, vm_re;
  logic [VW-1:0] vm_waddr, vm_raddr;
  logic [2*EW-1:0] vm_wdata, vm_rd;
  logic          stk_we, stk_re;
  logic [VW-1:0] stk_waddr, stk_raddr;
  logic [SW-1:0] stk_wdata, stk_rd;
  logic          fin_we, fin_re;
  logic [VW-1:0] fin_waddr, fin_raddr;
  vertex_t       fin_wdata, fin_rd;

  dts_ram #(.WIDTH(VERTEX_W), .DEPTH(MAX_EDGES)) u_targ_ram (
    .clk, .we(targ_we), .waddr(targ_waddr), .wdata(targ_wdata),
    .re(targ_re), .raddr(targ_raddr), .rdata(targ_rd));
  dts_ram #(.WIDTH(EW + 1), .DEPTH(MAX_EDGES)) u_link_ram (
    .clk, .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .re(link_re), .raddr(link_raddr), .rdata(link_rd));
  dts_ram #(.WIDTH(2 * EW), .DEPTH(MAX_VERTICES)) u_vert_ram (
    .clk, .we(vm_we), .waddr(vm_waddr), .wdata(vm_wdata),
    .re(vm_re), .raddr(vm_raddr), .rdata(vm_rd));
  dts_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_stack_ram (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .re(stk_re), .raddr(stk_raddr), .rdata(stk_rd));
  dts_ram #(.WIDTH(VERTEX_W), .DEPTH(MAX_VERTICES)) u_fin_ram (
    .clk, .we(fin_we), .waddr(fin_waddr), .wdata(fin_wdata),
    .re(fin_re), .raddr(fin_raddr), .rdata(fin_rd));

  always_comb begin
    if (nv_cfg_r == '0) begin
      nv = count_t'(1);
    end else if (nv_cfg_r > count_t'(MAX_VERTICES)) begin
      nv = count_t'(MAX_VERTICES);
    end else begin
      nv = nv_cfg_r;
    end
  end

  assign full         = (edge_cnt_r == CW'(MAX_EDGES));
  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.vertex        = out_vertex_r;
  assign out_ch.final_item    = out_final_r;
  assign out_ch.edges_dropped = out_drop_r;

  always_comb begin
    state_nxt      = state_r;
    nv_cfg_nxt     = nv_cfg_r;
    edge_cnt_nxt   = edge_cnt_r;
    drop_nxt       = drop_r;
    nonempty_nxt   = nonempty_r;
    visited_nxt    = visited_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    e_nxt          = e_r;
    tail_nxt       = tail_r;
    root_nxt       = root_r;
    sp_nxt         = sp_r;
    done_nxt       = done_r;
    idx_nxt        = idx_r;
    top_v_nxt      = top_v_r;
    top_cur_nxt    = top_cur_r;
    top_ok_nxt     = top_ok_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r;
    out_vertex_nxt = out_vertex_r;
    out_final_nxt  = out_final_r;
    out_drop_nxt   = out_drop_r;

    targ_we = 1'b0; targ_waddr = e_r; targ_wdata = b_r;
    targ_re = 1'b0; targ_raddr = top_cur_r;
    link_we = 1'b0; link_waddr = e_r; link_wdata = '0;
    link_re = 1'b0; link_raddr = top_cur_r;
    vm_we   = 1'b0; vm_waddr = a_r; vm_wdata = '0;
    vm_re   = 1'b0; vm_raddr = a_r;
    stk_we  = 1'b0; stk_waddr = '0; stk_wdata = '0;
    stk_re  = 1'b0; stk_raddr = '0;
    fin_we  = 1'b0; fin_waddr = done_r[VW-1:0]; fin_wdata = top_v_r;
    fin_re  = 1'b0; fin_raddr = idx_r[VW-1:0];

    if (cfg_we) begin
      nv_cfg_nxt = cfg_wdata;
    end
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.operation == OP_ADD_EDGE) begin
            if ({1'b0, in_ch.from_vertex} >= nv || {1'b0, in_ch.to_vertex} >= nv || full) begin
              drop_nxt = 1'b1;
            end else begin
              vm_re     = 1'b1;
              vm_raddr  = in_ch.from_vertex[VW-1:0];
              a_nxt     = in_ch.from_vertex[VW-1:0];
              b_nxt     = in_ch.to_vertex;
              e_nxt     = edge_cnt_r[EW-1:0];
              state_nxt = S_EADD;
            end
          end else begin
            root_nxt  = '0;
            done_nxt  = '0;
            state_nxt = S_ROOT;
          end
        end
      end
      S_EADD: begin
        targ_we      = 1'b1;
        link_we      = 1'b1;
        vm_we        = 1'b1;
        edge_cnt_nxt = edge_cnt_r + CW'(1);
        if (nonempty_r[a_r]) begin
          vm_wdata  = {vm_rd[2*EW-1:EW], e_r};
          tail_nxt  = vm_rd[EW-1:0];
          state_nxt = S_ELINK;
        end else begin
          vm_wdata          = {e_r, e_r};
          nonempty_nxt[a_r] = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      S_ELINK: begin
        // patch old tail: next = new edge, link valid
        link_we    = 1'b1;
        link_waddr = tail_r;
        link_wdata = {e_r, 1'b1};
        state_nxt  = S_IDLE;
      end
      S_ROOT: begin
        if (root_r >= nv) begin
          idx_nxt   = done_r - count_t'(1);
          state_nxt = S_EMITRD;
        end else if (visited_r[root_r[VW-1:0]]) begin
          root_nxt = root_r + count_t'(1);
        end else begin
          visited_nxt[root_r[VW-1:0]] = 1'b1;
          vm_re     = 1'b1;
          vm_raddr  = root_r[VW-1:0];
          state_nxt = S_RHEAD;
        end
      end
      S_RHEAD: begin
        top_v_nxt   = root_r[VERTEX_W-1:0];
        top_cur_nxt = vm_rd[2*EW-1:EW];
        top_ok_nxt  = nonempty_r[root_r[VW-1:0]];
        sp_nxt      = count_t'(1);
        state_nxt   = S_WALK;
      end
      S_WALK: begin
        if (top_ok_r) begin
          targ_re   = 1'b1;
          link_re   = 1'b1;
          state_nxt = S_EDGE;
        end else begin
          fin_we   = 1'b1;
          done_nxt = done_r + count_t'(1);
          sp_nxt   = sp_r - count_t'(1);
          if (sp_r == count_t'(1)) begin
            root_nxt  = root_r + count_t'(1);
            state_nxt = S_ROOT;
          end else begin
            stk_re    = 1'b1;
            stk_raddr = VW'(sp_r - count_t'(2));
            state_nxt = S_POP;
          end
        end
      end
      S_POP: begin
        {top_v_nxt, top_cur_nxt, top_ok_nxt} = stk_rd;
        state_nxt = S_WALK;
      end
      S_EDGE: begin
        top_cur_nxt = link_rd[EW:1];
        top_ok_nxt  = link_rd[0];
        state_nxt   = S_WALK;
        if ({1'b0, targ_rd} < nv && !visited_r[targ_rd[VW-1:0]] &&
            sp_r < count_t'(MAX_VERTICES)) begin
          visited_nxt[targ_rd[VW-1:0]] = 1'b1;
          stk_we    = 1'b1;
          stk_waddr = VW'(sp_r - count_t'(1));
          stk_wdata = {top_v_r, link_rd[EW:1], link_rd[0]};
          vm_re     = 1'b1;
          vm_raddr  = targ_rd[VW-1:0];
          pend_nxt  = targ_rd;
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        top_v_nxt   = pend_r;
        top_cur_nxt = vm_rd[2*EW-1:EW];
        top_ok_nxt  = nonempty_r[pend_r[VW-1:0]];
        sp_nxt      = sp_r + count_t'(1);
        state_nxt   = S_WALK;
      end
      S_EMITRD: begin
        fin_re    = 1'b1;
        state_nxt = S_EMITW;
      end
      S_EMITW: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_vertex_nxt = fin_rd;
          out_final_nxt  = (idx_r == '0);
          out_drop_nxt   = drop_r;
          if (idx_r == '0) begin
            edge_cnt_nxt = '0;
            drop_nxt     = 1'b0;
            nonempty_nxt = '0;
            visited_nxt  = '0;
            state_nxt    = S_IDLE;
          end else begin
            idx_nxt   = idx_r - count_t'(1);
            state_nxt = S_EMITRD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      nv_cfg_r    <= count_t'(64);
      edge_cnt_r  <= '0;
      drop_r      <= 1'b0;
      nonempty_r  <= '0;
      visited_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nv_cfg_r    <= nv_cfg_nxt;
      edge_cnt_r  <= edge_cnt_nxt;
      drop_r      <= drop_nxt;
      nonempty_r  <= nonempty_nxt;
      visited_r   <= visited_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    e_r          <= e_nxt;
    tail_r       <= tail_nxt;
    root_r       <= root_nxt;
    sp_r         <= sp_nxt;
    done_r       <= done_nxt;
    idx_r        <= idx_nxt;
    top_v_r      <= top_v_nxt;
    top_cur_r    <= top_cur_nxt;
    top_ok_r     <= top_ok_nxt;
    pend_r       <= pend_nxt;
    out_vertex_r <= out_vertex_nxt;
    out_final_r  <= out_final_nxt;
    out_drop_r   <= out_drop_nxt;
  end
endmodule
`default_nettype wire

/* sv/dts_chk.sv */
// dts_chk: port-level checks for dfs_topological_sort_core, bound to the core.
// Depends on dts_pkg for the vertex type and operation codes.
`default_nettype none
module dts_chk import dts_pkg::*; (
  input wire logic    clk,
  input wire logic    rst_n,
  input wire logic    in_valid,
  input wire logic    in_ready,
  input wire logic    in_operation,
  input wire logic    out_valid,
  input wire logic    out_ready,
  input wire vertex_t out_vertex,
  input wire logic    out_final
);
  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_vertex) && $stable(out_final))
    else $error("stalled result changed");

  // mid-run, no new request is taken
  a_busy_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final |-> !in_ready)
    else $error("request taken during a run");

  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == OP_RUN |=> !in_ready)
    else $error("ready right after run request");

  a_result_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == OP_ADD_EDGE |=> !($rose(out_valid)))
    else $error("result after edge request");
endmodule

bind dfs_topological_sort_core dts_chk u_dts_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_operation (in_ch.operation),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_vertex   (out_ch.vertex),
  .out_final    (out_ch.final_item)
);
`default_nettype wire

/* tb/testbench.sv */
// testbench: checks dfs_topological_sort_core against a behavioral model of the sort.
// Depends on dts_pkg, dts_if and the core; a scoreboard class holds expected orders.
`timescale 1ns / 100ps
`default_nettype none

class topo_scoreboard;
  // mirror of the graph
  int unsigned   tgt[256];
  int unsigned   nxt[256];
  bit            nxt_ok[256];
  int unsigned   head[64];
  bit            head_ok[64];
  int unsigned   tail[64];
  int unsigned   n_edges;
  bit            dropped;
  int unsigned   vcount_reg;
  dts_pkg::vertex_t exp_vertex[$];
  bit            exp_final[$];
  bit            exp_drop[$];
  int            errors;

  function new();
    n_edges = 0; dropped = 0; vcount_reg = 64; errors = 0;
    foreach (head_ok[i]) head_ok[i] = 0;
  endfunction

  function int unsigned vcount();
    if (vcount_reg == 0) return 1;
    if (vcount_reg > 64) return 64;
    return vcount_reg;
  endfunction

  function void note_request(bit op, int unsigned a, int unsigned b);
    int unsigned nv, sp, done, root, top, e, t;
    bit visited[64];
    int unsigned stk_v[64], stk_c[64];
    bit stk_ok[64];
    int unsigned order[64];
    nv = vcount();
    if (op == dts_pkg::OP_ADD_EDGE) begin
      if (a >= nv || b >= nv || n_edges >= 256) begin
        dropped = 1;
        return;
      end
      tgt[n_edges] = b;
      nxt_ok[n_edges] = 0;
      if (head_ok[a]) begin
        nxt[tail[a]] = n_edges;
        nxt_ok[tail[a]] = 1;
      end else begin
        head[a] = n_edges;
        head_ok[a] = 1;
      end
      tail[a] = n_edges;
      n_edges++;
      return;
    end
    foreach (visited[i]) visited[i] = 0;
    done = 0;
    for (root = 0; root < nv; root++) begin
      if (visited[root]) continue;
      visited[root] = 1;
      stk_v[0] = root; stk_c[0] = head[root]; stk_ok[0] = head_ok[root];
      sp = 1;
      while (sp > 0) begin
        top = sp - 1;
        if (stk_ok[top]) begin
          e = stk_c[top];
          t = tgt[e];
          stk_c[top] = nxt[e];
          stk_ok[top] = nxt_ok[e];
          if (t < nv && !visited[t] && sp < 64) begin
            visited[t] = 1;
            stk_v[sp] = t; stk_c[sp] = head[t]; stk_ok[sp] = head_ok[t];
            sp++;
          end
        end else begin
          if (done < 64) begin
            order[done] = stk_v[top];
            done++;
          end
          sp = top;
        end
      end
    end
    for (int k = 0; k < done; k++) begin
      exp_vertex.push_back(order[done-1-k]);
      exp_final.push_back(k + 1 == done);
      exp_drop.push_back(dropped);
    end
    n_edges = 0; dropped = 0;
    foreach (head_ok[i]) head_ok[i] = 0;
  endfunction

  function void check_result(dts_pkg::vertex_t v, bit fin, bit drp);
    if (exp_vertex.size() == 0) begin
      $display("%0t: unexpected result vertex=%0d final=%0b dropped=%0b", $time, v, fin, drp);
      errors++;
      return;
    end
    if (v !== exp_vertex[0] || fin !== exp_final[0] || drp !== exp_drop[0]) begin
      $display("%0t: expected vertex=%0d final=%0b dropped=%0b, got vertex=%0d final=%0b dropped=%0b",
               $time, exp_vertex[0], exp_final[0], exp_drop[0], v, fin, drp);
      errors++;
    end
    void'(exp_vertex.pop_front());
    void'(exp_final.pop_front());
    void'(exp_drop.pop_front());
  endfunction
endclass

module testbench;
  import dts_pkg::*;

  logic   clk = 0;
  logic   rst_n = 0;
  logic   cfg_we = 0;
  count_t cfg_wdata = '0;
  int     hold_off = 0;   // long receiver stall, counted below
  bit     stim_done = 0;

  dts_in_if  in_ch();
  dts_out_if out_ch();

  topo_scoreboard sb = new();

  dfs_topological_sort_core u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.operation = 0;
    in_ch.from_vertex = '0;
    in_ch.to_vertex = '0;
    out_ch.ready = 0;
  end

  // result side: random ready gaps, plus the long hold-off when requested
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0 || hold_off > 0) out_ch.ready <= 0;
      repeat (gap) @(posedge clk);
      while (hold_off > 0) begin
        hold_off <= hold_off - 1;
        @(posedge clk);
      end
      out_ch.ready <= 1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      sb.check_result(out_ch.vertex, out_ch.final_item, out_ch.edges_dropped);
    end
  end

  // valid stays high between back-to-back requests; wait_drained drops it
  task automatic send_request(bit op, int unsigned a, int unsigned b, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 7);
    if (!no_gap && $urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) in_ch.valid <= 0;
    repeat (gap) @(posedge clk);
    in_ch.valid <= 1;
    in_ch.operation <= op;
    in_ch.from_vertex <= a[5:0];
    in_ch.to_vertex <= b[5:0];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(op, a, b);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 0;
    while (sb.exp_vertex.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_vertex_count(int unsigned n);
    cfg_we <= 1;
    cfg_wdata <= n[6:0];
    @(posedge clk);
    cfg_we <= 0;
    sb.vcount_reg = n & 7'h7f;
  endtask

  // random DAG-ish load over n vertices, then a run
  task automatic random_graph(int unsigned n, int unsigned edges);
    int unsigned a, b;
    for (int i = 0; i < edges; i++) begin
      a = $urandom_range(0, n - 1);
      b = $urandom_range(0, n - 1);
      if ($urandom_range(0, 15) == 0) b = $urandom_range(0, 63);
      send_request(OP_ADD_EDGE, a, b);
    end
    send_request(OP_RUN, $urandom, $urandom);
  endtask

  initial begin
    int unsigned sent, n;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty run at reset count, a chain, cycle, out of range
    send_request(OP_RUN, 63, 63);
    set_vertex_count_after_drain();
    send_request(OP_ADD_EDGE, 0, 1);
    send_request(OP_ADD_EDGE, 1, 2);
    send_request(OP_ADD_EDGE, 2, 0);
    send_request(OP_ADD_EDGE, 0, 2);
    send_request(OP_ADD_EDGE, 3, 4);
    send_request(OP_ADD_EDGE, 7, 1);
    send_request(OP_ADD_EDGE, 1, 7);
    send_request(OP_RUN, 0, 0);
    wait_drained();
    set_vertex_count(0);
    send_request(OP_ADD_EDGE, 0, 0);
    send_request(OP_RUN, 0, 0);
    wait_drained();
    set_vertex_count(127);
    send_request(OP_ADD_EDGE, 63, 0);
    send_request(OP_ADD_EDGE, 0, 63);
    send_request(OP_ADD_EDGE, 62, 63);
    send_request(OP_RUN, 0, 0);
    wait_drained();
    // lowered count before run: edges to 10 stay stored but are skipped
    set_vertex_count(20);
    send_request(OP_ADD_EDGE, 5, 10);
    send_request(OP_ADD_EDGE, 10, 2);
    wait_drained();
    set_vertex_count(8);
    send_request(OP_ADD_EDGE, 1, 5);
    send_request(OP_RUN, 0, 0);
    wait_drained();
    // store full: more edge requests than the edge store holds, over the full vertex range
    set_vertex_count(64);
    for (int i = 0; i < 260; i++)
      send_request(OP_ADD_EDGE, $urandom_range(0, 63), $urandom_range(0, 63), 1);
    send_request(OP_RUN, 0, 0);
    wait_drained();

    // long receiver stall while further requests wait on the busy core
    hold_off = 300;
    set_vertex_count(6);
    for (int i = 0; i < 4; i++) random_graph(6, 4);
    wait_drained();

    sent = 0;
    while (sent < 110) begin
      case ($urandom_range(0, 5))
        0: n = 64;
        1: n = 1;
        default: n = $urandom_range(2, 12);
      endcase
      set_vertex_count(n);
      n = $urandom_range(0, 12);
      random_graph(sb.vcount(), n);
      sent += n + 1;
      wait_drained();
    end
    wait_drained();
    stim_done = 1;
  end

  task automatic set_vertex_count_after_drain();
    wait_drained();
    set_vertex_count(10);
  endtask

  initial begin
    wait (stim_done);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.exp_vertex.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
sv/dts_pkg.sv
sv/dts_if.sv
sv/dts_ram.sv
sv/dfs_topological_sort_core.sv
sv/dts_chk.sv
tb/testbench.sv
